/* hdl/rwa32_pkg.sv */
package rwa32_pkg;

    localparam int          MAX_WINDOW_DEF = 4096;
    localparam int          WLEN_W         = 13;
    localparam int          DATA_W         = 8;
    localparam int          SUM_W          = 16;
    localparam int          CSUM_W         = 2 * SUM_W;
    localparam int          APB_AW         = 3;
    localparam int          APB_DW         = 32;
    localparam logic [16:0] ADLER_MOD      = 17'd65521;
    localparam logic [31:0] ADLER_START    = 32'h0000_0001;
    localparam logic [31:0] HALF_MASK      = 32'h0000_FFFF;
    localparam logic [WLEN_W-1:0] WLEN_RST = 13'd4096;

    // register index taken from the word address
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // result word held in the output queue
    typedef struct packed {
        logic [CSUM_W-1:0] checksum;
        logic              window_full;
    } out_word_t;

    // per-word control carried down the pipeline
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              restart;
        logic              remove;
        logic              full;
    } step_ctrl_t;

endpackage

/* hdl/rwa32_in_if.sv */
interface rwa32_in_if
    import rwa32_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

/* hdl/rwa32_out_if.sv */
interface rwa32_out_if
    import rwa32_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CSUM_W-1:0] checksum;
    logic              window_full;

    modport source (output valid, output checksum, output window_full, input ready);
    modport sink   (input valid, input checksum, input window_full, output ready);
endinterface

/* hdl/rolling_window_adler32.sv */
// results pass s1, s2, s3 and the output queue; throughput: one word per cycle
//   while under eight words are in flight; each word reads and writes the ring
//   memory once at one address; both sums close their loop in a single cycle
// reset: sums to 1 and 0, fill count and write position cleared, window_length 4096;
//   the ring memory is not cleared and needs no clearing pass
module rolling_window_adler32
    import rwa32_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    rwa32_in_if.sink          byte_in,
    rwa32_out_if.source       sum_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int LEN_W   = $clog2(MAX_WINDOW + 2);
    localparam int PROD_W  = DATA_W + LEN_W;
    localparam int Q_DEPTH = 8;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DW'(wlen_reg) : '0;

    // stream position state
    logic [IDX_W-1:0] wpos_reg;
    logic [IDX_W-1:0] wpos_next;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] len_p1;
    logic [IDX_W-1:0] rd_pos;
    logic             accept;
    step_ctrl_t       ctrl_in;

    logic [QC_W-1:0]  inflight_reg;
    logic [QC_W-1:0]  inflight_next;

    assign byte_in.ready = (inflight_reg < QC_W'(Q_DEPTH));
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        logic [31:0]      wl32;
        logic [LEN_W-1:0] pos_ext;
        logic [LEN_W-1:0] fill_cur;
        logic [LEN_W-1:0] pos_inc;
        wl32 = 32'(wlen_reg);
        if (wl32 == 32'd0)
        begin
            wl32 = 32'd1;
        end
        if (wl32 > 32'(MAX_WINDOW))
        begin
            wl32 = 32'(MAX_WINDOW);
        end
        eff_len = LEN_W'(wl32);
        len_p1  = eff_len + LEN_W'(1);

        // a length change can leave the position or fill count out of range
        pos_ext  = byte_in.restart ? '0 : LEN_W'(wpos_reg);
        if (pos_ext >= eff_len)
        begin
            pos_ext = '0;
        end
        fill_cur = byte_in.restart ? '0 : fill_reg;
        if (fill_cur > len_p1)
        begin
            fill_cur = len_p1;
        end
        rd_pos = IDX_W'(pos_ext);

        pos_inc = pos_ext + LEN_W'(1);
        if (pos_inc >= eff_len)
        begin
            pos_inc = '0;
        end
        wpos_next = IDX_W'(pos_inc);
        fill_next = (fill_cur < len_p1) ? fill_cur + LEN_W'(1) : fill_cur;

        ctrl_in.data_byte = byte_in.data_byte;
        ctrl_in.restart   = byte_in.restart;
        ctrl_in.remove    = (fill_next > eff_len);
        ctrl_in.full      = (fill_next >= eff_len);
    end

    // ring memory, read-before-write at the same address
    logic [DATA_W-1:0] window_mem [MAX_WINDOW];
    logic [DATA_W-1:0] pop1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop1_reg         <= window_mem[rd_pos];
            window_mem[rd_pos] <= byte_in.data_byte;
        end
    end

    // pipeline
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    step_ctrl_t        s1_ctrl_reg;
    step_ctrl_t        s2_ctrl_reg;
    step_ctrl_t        s3_ctrl_reg;
    logic [LEN_W-1:0]  s1_lenp1_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [DATA_W-1:0] pop2_reg;
    logic [DATA_W-1:0] pop3_reg;
    logic [16:0]       sub2_3_reg;
    logic [16:0]       sub2_next;

    always_ff @(posedge clk)
    begin
        s1_ctrl_reg  <= ctrl_in;
        s1_lenp1_reg <= len_p1;
        s2_ctrl_reg  <= s1_ctrl_reg;
        prod2_reg    <= PROD_W'(pop1_reg) * PROD_W'(s1_lenp1_reg);
        pop2_reg     <= pop1_reg;
        s3_ctrl_reg  <= s2_ctrl_reg;
        pop3_reg     <= pop2_reg;
        sub2_3_reg   <= sub2_next;
    end

    // (1 + pop*(len+1)) mod 65521, folding 2^16 as 15
    always_comb
    begin
        logic [31:0] x;
        logic [31:0] y;
        x = ADLER_START + 32'(prod2_reg);
        y = (x >> 16) * 32'd15 + (x & HALF_MASK);
        if (y >= 32'(ADLER_MOD))
        begin
            y = y - 32'(ADLER_MOD);
        end
        sub2_next = y[16:0];
    end

    // sum update, loop closed through first_reg and second_reg
    logic [SUM_W-1:0] first_reg;
    logic [SUM_W-1:0] second_reg;
    logic [SUM_W-1:0] first_next;
    logic [SUM_W-1:0] second_next;

    always_comb
    begin
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] p;
        p = 17'(pop3_reg);
        a = s3_ctrl_reg.restart ? 17'(ADLER_START & HALF_MASK) : 17'(first_reg);
        b = s3_ctrl_reg.restart ? 17'((ADLER_START >> 16) & HALF_MASK) : 17'(second_reg);
        a = a + 17'(s3_ctrl_reg.data_byte);
        if (a >= ADLER_MOD)
        begin
            a = a - ADLER_MOD;
        end
        b = b + a;
        if (b >= ADLER_MOD)
        begin
            b = b - ADLER_MOD;
        end
        if (s3_ctrl_reg.remove)
        begin
            a = (a >= p) ? a - p : ADLER_MOD - p + a;
            b = (b >= sub2_3_reg) ? b - sub2_3_reg : ADLER_MOD - sub2_3_reg + b;
        end
        first_next  = a[SUM_W-1:0];
        second_next = b[SUM_W-1:0];
    end

    // output queue
    out_word_t        q_mem [Q_DEPTH];
    logic [QP_W-1:0]  q_wr_reg;
    logic [QP_W-1:0]  q_rd_reg;
    logic [QC_W-1:0]  q_cnt_reg;
    logic             q_pop;

    assign sum_out.valid       = (q_cnt_reg != '0);
    assign sum_out.checksum    = q_mem[q_rd_reg].checksum;
    assign sum_out.window_full = q_mem[q_rd_reg].window_full;
    assign q_pop               = sum_out.valid && sum_out.ready;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            q_mem[q_wr_reg] <= '{checksum: {second_next, first_next},
                                 window_full: s3_ctrl_reg.full};
        end
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept && !q_pop)
        begin
            inflight_next = inflight_reg + QC_W'(1);
        end
        else if (!accept && q_pop)
        begin
            inflight_next = inflight_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg     <= WLEN_RST;
            wpos_reg     <= '0;
            fill_reg     <= '0;
            first_reg    <= SUM_W'(ADLER_START & HALF_MASK);
            second_reg   <= SUM_W'((ADLER_START >> 16) & HALF_MASK);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            q_wr_reg     <= '0;
            q_rd_reg     <= '0;
            q_cnt_reg    <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                wlen_reg <= pwdata[WLEN_W-1:0];
            end
            if (accept)
            begin
                wpos_reg <= wpos_next;
                fill_reg <= fill_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                first_reg  <= first_next;
                second_reg <= second_next;
                q_wr_reg   <= q_wr_reg + QP_W'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + QP_W'(1);
            end
            if (s3_valid_reg && !q_pop)
            begin
                q_cnt_reg <= q_cnt_reg + QC_W'(1);
            end
            else if (!s3_valid_reg && q_pop)
            begin
                q_cnt_reg <= q_cnt_reg - QC_W'(1);
            end
            inflight_reg <= inflight_next;
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rwa32_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_500_000;
    localparam int          RANDOM_WORDS = 700;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          END_CYCLES   = 16;
    localparam int unsigned MODULUS      = ADLER_MOD;
    localparam logic [APB_AW-1:0] ADDR_WLEN  = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_WINDOW_LENGTH, 2'b00};

    typedef enum logic [1:0] {ROW_WORD, ROW_SETLEN, ROW_SPARE} plan_kind_e;
    typedef enum int {MIX_ANY, MIX_HIGH, MIX_EDGE} byte_mix_e;

    typedef struct packed {
        plan_kind_e        kind;
        logic [APB_DW-1:0] value;
        logic [DATA_W-1:0] data_byte;
        logic              restart;
        logic              typed;
        out_word_t         want;
    } plan_row_t;

    // window of one byte gives the checksum of that byte alone
    localparam int PLAN_ROWS = 29;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_WORD,   32'd0,    8'h00, 1'b0, 1'b1, '{32'h0001_0001, 1'b0}},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h80, 1'b1, 1'b1, '{32'h0081_0081, 1'b0}},
        '{ROW_WORD,   32'd0,    8'h00, 1'b1, 1'b1, '{32'h0001_0001, 1'b0}},
        '{ROW_SETLEN, 32'd1,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b1, 1'b1, '{32'h0100_0100, 1'b1}},
        '{ROW_WORD,   32'd0,    8'h00, 1'b0, 1'b1, '{32'h0001_0001, 1'b1}},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b0, 1'b1, '{32'h0100_0100, 1'b1}},
        '{ROW_WORD,   32'd0,    8'h01, 1'b0, 1'b1, '{32'h0002_0002, 1'b1}},
        // zero length behaves as one
        '{ROW_SETLEN, 32'd0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h10, 1'b0, 1'b1, '{32'h0011_0011, 1'b1}},
        // write to an unmapped register must be ignored
        '{ROW_SPARE,  32'd5,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h20, 1'b0, 1'b1, '{32'h0021_0021, 1'b1}},
        // oversized length behaves as the ring depth
        '{ROW_SETLEN, 32'd8191, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b1, 1'b1, '{32'h0100_0100, 1'b0}},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h7F, 1'b0, 1'b0, '0},
        '{ROW_SETLEN, 32'd2,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b1, 1'b1, '{32'h0100_0100, 1'b0}},
        '{ROW_WORD,   32'd0,    8'hFF, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h80, 1'b0, 1'b0, '0},
        // length changes with the stream running, no restart
        '{ROW_SETLEN, 32'd3,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h55, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'hAA, 1'b0, 1'b0, '0},
        '{ROW_SETLEN, 32'd2,    8'h00, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h01, 1'b0, 1'b0, '0},
        '{ROW_WORD,   32'd0,    8'h02, 1'b0, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rwa32_in_if  byte_in ();
    rwa32_out_if sum_out ();

    rolling_window_adler32 dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .sum_out (sum_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [SUM_W-1:0]  sum_lo;
    logic [SUM_W-1:0]  sum_hi;
    logic [DATA_W-1:0] ring_mem [MAX_WINDOW_DEF];
    bit                ring_seen [MAX_WINDOW_DEF];
    int unsigned       ring_pos;
    int unsigned       fill_cnt;
    logic [WLEN_W-1:0] wlen_cfg;

    out_word_t   pending_sums [$];
    bit          restart_pending;
    bit          hold_request;
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned restarts_sent;
    int unsigned results_seen;
    int unsigned full_seen;
    int unsigned settings_used;
    int unsigned holds_done;

    function automatic int unsigned window_span();
        if (wlen_cfg == '0)
            return 1;
        if (wlen_cfg > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return 32'(wlen_cfg);
    endfunction

    function automatic bit ring_covered();
        int unsigned span;
        span = window_span();
        for (int unsigned i = 0; i < span; i++)
            if (!ring_seen[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned mod_minus(input int unsigned x, input int unsigned y);
        return (x >= y) ? (x - y) : (MODULUS - y + x);
    endfunction

    function automatic out_word_t adler_window_step(input logic [DATA_W-1:0] b,
                                                    input logic rs);
        int unsigned span;
        int unsigned a;
        int unsigned s;
        int unsigned oldest;
        out_word_t   res;
        if (rs)
        begin
            sum_lo   = ADLER_START[15:0];
            sum_hi   = ADLER_START[31:16];
            fill_cnt = 0;
            ring_pos = 0;
        end
        span = window_span();
        if (ring_pos >= span)
            ring_pos = 0;
        if (fill_cnt > span + 1)
            fill_cnt = span + 1;
        a = 32'(sum_lo) + 32'(b);
        s = (32'(sum_hi) + a) % MODULUS;
        a = a % MODULUS;
        oldest = 32'(ring_mem[ring_pos]);
        ring_mem[ring_pos]  = b;
        ring_seen[ring_pos] = 1'b1;
        ring_pos++;
        if (ring_pos >= span)
            ring_pos = 0;
        if (fill_cnt < span + 1)
            fill_cnt++;
        if (fill_cnt > span)
        begin
            a = mod_minus(a, oldest);
            s = mod_minus(s, (1 + oldest * (span + 1)) % MODULUS);
        end
        sum_lo = SUM_W'(a & HALF_MASK);
        sum_hi = SUM_W'(s & HALF_MASK);
        res.checksum    = {sum_hi, sum_lo};
        res.window_full = (fill_cnt >= span);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_byte(input byte_mix_e mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_HIGH: return (r < 85) ? 8'hFF : DATA_W'($urandom);
            MIX_EDGE: return (r < 45) ? 8'h00 : (r < 90) ? 8'hFF : DATA_W'($urandom);
            default:  return DATA_W'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        val = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_length_reg();
        logic [APB_DW-1:0] seen;
        apb_read(ADDR_WLEN, seen);
        if (seen !== APB_DW'(wlen_cfg))
        begin
            mismatches++;
            $error("window_length readback: expected %0d, got %0d", wlen_cfg, seen);
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            byte_in.valid     <= 1'b0;
            byte_in.data_byte <= DATA_W'($urandom);
            byte_in.restart   <= 1'($urandom);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_in.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [APB_DW-1:0] len);
        logic [APB_DW-1:0] word;
        wait_drained();
        // junk above the field must not reach the register
        word = $urandom;
        word[WLEN_W-1:0] = len[WLEN_W-1:0];
        apb_write(ADDR_WLEN, word);
        wlen_cfg = word[WLEN_W-1:0];
        check_length_reg();
        // a ring entry never written must not be popped after a length change
        restart_pending = !ring_covered();
        settings_used++;
    endtask

    task automatic poke_spare(input logic [APB_DW-1:0] val);
        wait_drained();
        apb_write(ADDR_SPARE, val);
        check_length_reg();
    endtask

    task automatic send_word(input logic [DATA_W-1:0] b, input logic rs,
                             input logic typed, input out_word_t want);
        logic      rs_eff;
        out_word_t res;
        rs_eff = rs | restart_pending;
        restart_pending = 1'b0;
        @(negedge clk);
        byte_in.valid     <= 1'b1;
        byte_in.data_byte <= b;
        byte_in.restart   <= rs_eff;
        do @(posedge clk); while (!byte_in.ready);
        res = adler_window_step(b, rs_eff);
        pending_sums.push_back(typed ? want : res);
        words_sent++;
        if (rs_eff)
            restarts_sent++;
    endtask

    task automatic run_phase(input int n, input int restart_odds, input byte_mix_e mix,
                             input bit burst, input int drain_at);
        logic rs;
        for (int k = 0; k < n; k++)
        begin
            if (k == drain_at || (!burst && $urandom_range(0, 149) == 0))
                wait_drained();
            else if (!burst && $urandom_range(0, 99) < 30)
                idle_cycles(pick_gap());
            rs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
            send_word(pick_byte(mix), rs, 1'b0, '0);
        end
    endtask

    // receiver: random stalls, calm stretches, and long hold-offs on request
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        sum_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
                holds_done++;
            end
            if (stall_left > 0)
            begin
                sum_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                sum_out.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 299) == 0)
                    calm_left = $urandom_range(50, 300);
                else if ($urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && sum_out.valid && sum_out.ready)
        begin
            results_seen++;
            if (sum_out.window_full)
                full_seen++;
            if (pending_sums.size() == 0)
            begin
                mismatches++;
                $error("result word with nothing expected: checksum %h", sum_out.checksum);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (sum_out.checksum !== want.checksum)
                begin
                    mismatches++;
                    $error("checksum: expected %h, got %h",
                           want.checksum, sum_out.checksum);
                end
                if (sum_out.window_full !== want.window_full)
                begin
                    mismatches++;
                    $error("window_full: expected %b, got %b",
                           want.window_full, sum_out.window_full);
                end
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_sums.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [WLEN_W-1:0] len;
        int                n;
        int                pick;
        int unsigned       base;
        bit                burst;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = '0;
        byte_in.restart   = 1'b0;
        sum_lo            = ADLER_START[15:0];
        sum_hi            = ADLER_START[31:16];
        ring_pos          = 0;
        fill_cnt          = 0;
        wlen_cfg          = WLEN_RST;
        restart_pending   = 1'b0;
        hold_request      = 1'b0;
        mismatches        = 0;
        words_sent        = 0;
        restarts_sent     = 0;
        results_seen      = 0;
        full_seen         = 0;
        settings_used     = 0;
        holds_done        = 0;
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
        begin
            ring_mem[i]  = '0;
            ring_seen[i] = 1'b0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_length_reg();

        foreach (PLAN[i])
        begin
            case (PLAN[i].kind)
                ROW_SETLEN: set_window(PLAN[i].value);
                ROW_SPARE:  poke_spare(PLAN[i].value);
                default:    send_word(PLAN[i].data_byte, PLAN[i].restart,
                                      PLAN[i].typed, PLAN[i].want);
            endcase
        end

        base = words_sent;

        // back-pressure: receiver holds off while the sender keeps offering
        set_window($urandom_range(5, 20));
        hold_request = 1'b1;
        run_phase(200, 40, MIX_HIGH, 1'b1, 120);

        while (words_sent - base < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                len = WLEN_W'($urandom_range(1, 16));
                n   = 3 * int'(len) + $urandom_range(4, 24);
            end
            else if (pick < 75)
            begin
                len = WLEN_W'($urandom_range(17, 64));
                n   = 2 * int'(len) + $urandom_range(4, 20);
            end
            else if (pick < 85)
            begin
                len = WLEN_W'($urandom_range(65, 300));
                n   = int'(len) + $urandom_range(10, 60);
            end
            else if (pick < 90)
            begin
                len = '0;
                n   = $urandom_range(5, 20);
            end
            else if (pick < 95)
            begin
                len = WLEN_W'($urandom_range(MAX_WINDOW_DEF + 1, (1 << WLEN_W) - 1));
                n   = $urandom_range(10, 40);
            end
            else
            begin
                len = WLEN_W'($urandom_range(1000, MAX_WINDOW_DEF));
                n   = $urandom_range(10, 40);
            end
            set_window(APB_DW'(len));
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                hold_request = 1'b1;
            run_phase(n, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60),
                      byte_mix_e'($urandom_range(0, 2)), burst, -1);
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("sent %0d words (%0d with restart) across %0d window settings",
                 words_sent, restarts_sent, settings_used);
        $display("checked %0d results, %0d with full window, %0d receiver hold-offs",
                 results_seen, full_seen, holds_done);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
